[src/laa_pkg.sv]
// Shared types, codes and defaults for the lifetime aliasing allocator.
`timescale 1ns / 1ps
package laa_pkg;

  localparam int ACTIVE_DEPTH_DEF = 64;
  localparam int FREE_DEPTH_DEF   = 64;
  localparam int SIZE_BITS_DEF    = 40;
  localparam int TIME_BITS_DEF    = 16;
  localparam int ALIGN_BITS       = 5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ACT_FULL  = 2'd1;
  localparam logic [1:0] ST_FREE_FULL = 2'd2;
  localparam logic [1:0] ST_OVF       = 2'd3;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // take the input beat
    OP_ARD,       // read active entry
    OP_AEVAL,     // compare active entry against best expiry
    OP_RET_RD,    // read best entry, drop its valid bit
    OP_RLOAD,     // latch the block being released
    OP_FRD,       // read free list entry
    OP_POS_GE,    // latch following neighbor
    OP_POS_LT,    // latch preceding neighbor
    OP_ABSORB,    // merge following neighbor into released block
    OP_MV_WR,     // write last free read data to a new slot
    OP_CNT_DEC,
    OP_PMERGE,    // grow preceding neighbor
    OP_INSERT,    // insert released block, count up
    OP_ST2,
    OP_FIT_A,     // align candidate block start, block end
    OP_FIT_TAKE,  // claim candidate block
    OP_FIT_W,     // write leftover tail of claimed block
    OP_GROW_A,    // align top of heap
    OP_GROW_B,    // grow heap
    OP_REC,       // record allocation in active table
    OP_ST1,
    OP_OUT        // load result register
  } dp_op_t;

  typedef struct packed {
    logic best_found;
    logic pos_ge;
    logic merge_n;
    logic merge_p;
    logic rsz_zero;
    logic fit_ok;
    logic fit_exact;
    logic slot_valid;
  } dp_stat_t;

endpackage

[src/laa_dp.sv]
// Datapath: tables, free list memory, alignment and fit arithmetic, result register.
`timescale 1ns / 1ps
module laa_dp #(
  parameter int ACTIVE_DEPTH = laa_pkg::ACTIVE_DEPTH_DEF,
  parameter int FREE_DEPTH   = laa_pkg::FREE_DEPTH_DEF,
  parameter int SIZE_BITS    = laa_pkg::SIZE_BITS_DEF,
  parameter int TIME_BITS    = laa_pkg::TIME_BITS_DEF,
  localparam int AW = $clog2(ACTIVE_DEPTH),
  localparam int FW = $clog2(FREE_DEPTH),
  localparam int CW = $clog2(FREE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  laa_pkg::dp_op_t               op,
  input  logic [AW-1:0]                 a_addr,
  input  logic [FW-1:0]                 f_addr,
  input  logic                          in_first,
  input  logic [TIME_BITS-1:0]          in_begin,
  input  logic [TIME_BITS-1:0]          in_end,
  input  logic [SIZE_BITS-1:0]          in_size,
  input  logic [laa_pkg::ALIGN_BITS-1:0] in_align,
  output laa_pkg::dp_stat_t             stat,
  output logic [CW-1:0]                 free_cnt,
  output logic [SIZE_BITS-1:0]          res_offset,
  output logic [SIZE_BITS-1:0]          res_total,
  output logic                          res_reused,
  output logic [1:0]                    res_status
);

  localparam int SB = SIZE_BITS;

  logic [TIME_BITS-1:0] aend_mem [ACTIVE_DEPTH];
  logic [SB-1:0]        aoff_mem [ACTIVE_DEPTH];
  logic [SB-1:0]        asz_mem  [ACTIVE_DEPTH];
  logic [SB-1:0]        foff_mem [FREE_DEPTH];
  logic [SB-1:0]        fsz_mem  [FREE_DEPTH];

  logic [ACTIVE_DEPTH-1:0] avalid_r;
  logic [CW-1:0]           cnt_r;
  logic [SB-1:0]           top_r;
  logic [1:0]              status_r;
  logic                    best_found_r;

  logic [TIME_BITS-1:0] beg_r, end_r, aend_q, best_end_r;
  logic [SB-1:0]        size_r, aoff_q, asz_q, foff_q, fsz_q;
  logic [laa_pkg::ALIGN_BITS-1:0] lg_r;
  logic [AW-1:0]        best_idx_r;
  logic [SB-1:0]        roff_r, rsz_r, nxt_off_r, nxt_sz_r, prv_off_r, prv_sz_r;
  logic                 found_r, have_prv_r, al_ok_r, reused_r;
  logic [SB-1:0]        st_r, offset_r, stored_r;
  logic [SB:0]          bend_r, fin_r;

  // alignment
  logic [SB-1:0] al_in, lg_mask, al_res;
  logic [SB:0]   al_sum, al_val, fin, grow_sum;
  logic          al_big, al_ok;
  logic [AW-1:0] a_rd;

  always_comb begin
    al_in   = (op == laa_pkg::OP_GROW_A) ? top_r : foff_q;
    lg_mask = ~({SB{1'b1}} << lg_r);
    al_sum  = {1'b0, al_in} + {1'b0, lg_mask};
    al_val  = al_sum & {1'b1, ~lg_mask};
    al_big  = (32'(lg_r) >= SB);
    al_ok   = al_big ? (al_in == '0) : !al_val[SB];
    al_res  = al_big ? '0 : al_val[SB-1:0];
    fin      = {1'b0, st_r} + {1'b0, size_r};
    grow_sum = fin;
    a_rd     = (op == laa_pkg::OP_RET_RD) ? best_idx_r : a_addr;
  end

  always_comb begin
    stat.best_found = best_found_r;
    stat.pos_ge     = (foff_q >= roff_r);
    stat.merge_n    = found_r && (({1'b0, roff_r} + {1'b0, rsz_r}) == {1'b0, nxt_off_r});
    stat.merge_p    = have_prv_r && (({1'b0, prv_off_r} + {1'b0, prv_sz_r}) == {1'b0, roff_r});
    stat.rsz_zero   = (rsz_r == '0);
    stat.fit_ok     = al_ok_r && (fin <= bend_r);
    stat.fit_exact  = (fin_r == bend_r);
    stat.slot_valid = avalid_r[a_addr];
  end

  assign free_cnt = cnt_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avalid_r     <= '0;
      cnt_r        <= '0;
      top_r        <= '0;
      best_found_r <= 1'b0;
    end else begin
      unique case (op)
        laa_pkg::OP_LOAD: begin
          if (in_first) begin
            avalid_r <= '0;
            cnt_r    <= '0;
            top_r    <= '0;
          end
          best_found_r <= 1'b0;
        end
        laa_pkg::OP_AEVAL: begin
          if (avalid_r[a_addr] && aend_q < beg_r && (!best_found_r || aend_q < best_end_r))
            best_found_r <= 1'b1;
        end
        laa_pkg::OP_RET_RD: avalid_r[best_idx_r] <= 1'b0;
        laa_pkg::OP_RLOAD:  best_found_r <= 1'b0;
        laa_pkg::OP_CNT_DEC: cnt_r <= cnt_r - 1'b1;
        laa_pkg::OP_INSERT:  cnt_r <= cnt_r + 1'b1;
        laa_pkg::OP_GROW_B: begin
          if (!al_ok_r || grow_sum[SB]) top_r <= {SB{1'b1}};
          else top_r <= grow_sum[SB-1:0];
        end
        laa_pkg::OP_REC: avalid_r[a_addr] <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      laa_pkg::OP_LOAD: begin
        beg_r    <= in_begin;
        end_r    <= in_end;
        size_r   <= (in_size == '0) ? SB'(1) : in_size;
        lg_r     <= in_align;
        status_r <= laa_pkg::ST_OK;
        reused_r <= 1'b0;
      end
      laa_pkg::OP_AEVAL: begin
        if (avalid_r[a_addr] && aend_q < beg_r && (!best_found_r || aend_q < best_end_r)) begin
          best_idx_r <= a_addr;
          best_end_r <= aend_q;
        end
      end
      laa_pkg::OP_RLOAD: begin
        roff_r     <= aoff_q;
        rsz_r      <= asz_q;
        found_r    <= 1'b0;
        have_prv_r <= 1'b0;
      end
      laa_pkg::OP_POS_GE: begin
        found_r   <= 1'b1;
        nxt_off_r <= foff_q;
        nxt_sz_r  <= fsz_q;
      end
      laa_pkg::OP_POS_LT: begin
        have_prv_r <= 1'b1;
        prv_off_r  <= foff_q;
        prv_sz_r   <= fsz_q;
      end
      laa_pkg::OP_ABSORB: rsz_r <= rsz_r + nxt_sz_r;
      laa_pkg::OP_ST2: begin
        if (status_r < laa_pkg::ST_FREE_FULL) status_r <= laa_pkg::ST_FREE_FULL;
      end
      laa_pkg::OP_ST1: begin
        if (status_r < laa_pkg::ST_ACT_FULL) status_r <= laa_pkg::ST_ACT_FULL;
      end
      laa_pkg::OP_FIT_A, laa_pkg::OP_GROW_A: begin
        st_r    <= al_res;
        al_ok_r <= al_ok;
        bend_r  <= {1'b0, foff_q} + {1'b0, fsz_q};
      end
      laa_pkg::OP_FIT_TAKE: begin
        offset_r <= st_r;
        stored_r <= size_r;
        reused_r <= 1'b1;
        fin_r    <= fin;
      end
      laa_pkg::OP_GROW_B: begin
        if (!al_ok_r) begin
          offset_r <= {SB{1'b1}};
          stored_r <= '0;
          status_r <= laa_pkg::ST_OVF;
        end else if (grow_sum[SB]) begin
          offset_r <= st_r;
          stored_r <= ~st_r;
          status_r <= laa_pkg::ST_OVF;
        end else begin
          offset_r <= st_r;
          stored_r <= size_r;
        end
      end
      laa_pkg::OP_OUT: begin
        res_offset <= offset_r;
        res_total  <= top_r;
        res_reused <= reused_r;
        res_status <= status_r;
      end
      default: ;
    endcase
  end

  // active table memory
  always_ff @(posedge clk) begin
    if (op == laa_pkg::OP_REC) begin
      aend_mem[a_addr] <= end_r;
      aoff_mem[a_addr] <= offset_r;
      asz_mem[a_addr]  <= stored_r;
    end
    if (op == laa_pkg::OP_ARD || op == laa_pkg::OP_RET_RD) begin
      aend_q <= aend_mem[a_rd];
      aoff_q <= aoff_mem[a_rd];
      asz_q  <= asz_mem[a_rd];
    end
  end

  // free list memory
  always_ff @(posedge clk) begin
    unique case (op)
      laa_pkg::OP_MV_WR: begin
        foff_mem[f_addr] <= foff_q;
        fsz_mem[f_addr]  <= fsz_q;
      end
      laa_pkg::OP_INSERT: begin
        foff_mem[f_addr] <= roff_r;
        fsz_mem[f_addr]  <= rsz_r;
      end
      laa_pkg::OP_FIT_W: begin
        foff_mem[f_addr] <= fin_r[SB-1:0];
        fsz_mem[f_addr]  <= SB'(bend_r - fin_r);
      end
      laa_pkg::OP_PMERGE: fsz_mem[f_addr] <= prv_sz_r + rsz_r;
      laa_pkg::OP_FRD: begin
        foff_q <= foff_mem[f_addr];
        fsz_q  <= fsz_mem[f_addr];
      end
      default: ;
    endcase
  end

endmodule

[src/laa_ctrl.sv]
// Controller: sequences retire scans, free list edits, fit search and result handoff.
`timescale 1ns / 1ps
module laa_ctrl #(
  parameter int ACTIVE_DEPTH = laa_pkg::ACTIVE_DEPTH_DEF,
  parameter int FREE_DEPTH   = laa_pkg::FREE_DEPTH_DEF,
  localparam int AW  = $clog2(ACTIVE_DEPTH),
  localparam int FW  = $clog2(FREE_DEPTH),
  localparam int CW  = $clog2(FREE_DEPTH + 1),
  localparam int IW  = (AW > CW) ? AW : CW,
  localparam int IW1 = IW + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  laa_pkg::dp_stat_t stat,
  input  logic [CW-1:0]     free_cnt,
  output laa_pkg::dp_op_t   op,
  output logic [AW-1:0]     a_addr,
  output logic [FW-1:0]     f_addr
);

  typedef enum logic [4:0] {
    S_IDLE, S_SC_RD, S_SC_EV, S_RET_CHK, S_RET_LD, S_REL, S_POS_RD, S_POS_EV,
    S_MERGE_N, S_SD_CHK, S_SD_RD, S_SD_WR, S_MERGE_P, S_SU_CHK, S_SU_RD, S_SU_WR,
    S_FIT_RD, S_FIT_A, S_FIT_B, S_FIT_W, S_GROW_A, S_GROW_B, S_REC_SCAN, S_OUT
  } state_t;

  localparam logic [IW-1:0] LAST_A = IW'(ACTIVE_DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt, idx_inc, idx_dec;
  logic [CW-1:0] pos_r, pos_nxt, pos_dec;
  logic          ret_r, ret_nxt;   // 1: shift-down was a fit removal
  logic          out_valid_r, out_valid_nxt;
  logic          last_free;

  always_comb begin
    idx_inc   = idx_r + 1'b1;
    idx_dec   = idx_r - 1'b1;
    pos_dec   = pos_r - 1'b1;
    last_free = (IW1'(idx_r) + IW1'(1)) == IW1'(free_cnt);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r && !out_tready;
    op            = laa_pkg::OP_NONE;
    a_addr        = idx_r[AW-1:0];
    f_addr        = idx_r[FW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = laa_pkg::OP_LOAD;
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        op        = laa_pkg::OP_ARD;
        state_nxt = S_SC_EV;
      end
      S_SC_EV: begin
        op = laa_pkg::OP_AEVAL;
        if (idx_r == LAST_A) state_nxt = S_RET_CHK;
        else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SC_RD;
        end
      end
      S_RET_CHK: begin
        if (stat.best_found) begin
          op        = laa_pkg::OP_RET_RD;
          state_nxt = S_RET_LD;
        end else begin
          idx_nxt   = '0;
          state_nxt = (free_cnt == '0) ? S_GROW_A : S_FIT_RD;
        end
      end
      S_RET_LD: begin
        op        = laa_pkg::OP_RLOAD;
        state_nxt = S_REL;
      end
      S_REL: begin
        idx_nxt = '0;
        pos_nxt = '0;
        if (stat.rsz_zero) state_nxt = S_SC_RD;
        else if (free_cnt == '0) state_nxt = S_MERGE_N;
        else state_nxt = S_POS_RD;
      end
      S_POS_RD: begin
        op        = laa_pkg::OP_FRD;
        state_nxt = S_POS_EV;
      end
      S_POS_EV: begin
        if (stat.pos_ge) begin
          op        = laa_pkg::OP_POS_GE;
          pos_nxt   = CW'(idx_r);
          state_nxt = S_MERGE_N;
        end else begin
          op = laa_pkg::OP_POS_LT;
          if (last_free) begin
            pos_nxt   = free_cnt;
            state_nxt = S_MERGE_N;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_POS_RD;
          end
        end
      end
      S_MERGE_N: begin
        if (stat.merge_n) begin
          op        = laa_pkg::OP_ABSORB;
          idx_nxt   = IW'(pos_r);
          ret_nxt   = 1'b0;
          state_nxt = S_SD_CHK;
        end else state_nxt = S_MERGE_P;
      end
      S_SD_CHK: begin
        if ((IW1'(idx_r) + IW1'(1)) < IW1'(free_cnt)) state_nxt = S_SD_RD;
        else begin
          op = laa_pkg::OP_CNT_DEC;
          if (ret_r) begin
            idx_nxt   = '0;
            state_nxt = S_REC_SCAN;
          end else state_nxt = S_MERGE_P;
        end
      end
      S_SD_RD: begin
        op        = laa_pkg::OP_FRD;
        f_addr    = idx_inc[FW-1:0];
        state_nxt = S_SD_WR;
      end
      S_SD_WR: begin
        op        = laa_pkg::OP_MV_WR;
        idx_nxt   = idx_inc;
        state_nxt = S_SD_CHK;
      end
      S_MERGE_P: begin
        idx_nxt = '0;
        if (stat.merge_p) begin
          op        = laa_pkg::OP_PMERGE;
          f_addr    = pos_dec[FW-1:0];
          state_nxt = S_SC_RD;
        end else if (free_cnt == CW'(FREE_DEPTH)) begin
          op        = laa_pkg::OP_ST2;
          state_nxt = S_SC_RD;
        end else begin
          idx_nxt   = IW'(free_cnt);
          state_nxt = S_SU_CHK;
        end
      end
      S_SU_CHK: begin
        if (idx_r > IW'(pos_r)) state_nxt = S_SU_RD;
        else begin
          op        = laa_pkg::OP_INSERT;
          f_addr    = pos_r[FW-1:0];
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end
      end
      S_SU_RD: begin
        op        = laa_pkg::OP_FRD;
        f_addr    = idx_dec[FW-1:0];
        state_nxt = S_SU_WR;
      end
      S_SU_WR: begin
        op        = laa_pkg::OP_MV_WR;
        idx_nxt   = idx_dec;
        state_nxt = S_SU_CHK;
      end
      S_FIT_RD: begin
        op        = laa_pkg::OP_FRD;
        state_nxt = S_FIT_A;
      end
      S_FIT_A: begin
        op        = laa_pkg::OP_FIT_A;
        state_nxt = S_FIT_B;
      end
      S_FIT_B: begin
        if (stat.fit_ok) begin
          op        = laa_pkg::OP_FIT_TAKE;
          state_nxt = S_FIT_W;
        end else if (last_free) state_nxt = S_GROW_A;
        else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FIT_RD;
        end
      end
      S_FIT_W: begin
        if (stat.fit_exact) begin
          ret_nxt   = 1'b1;
          state_nxt = S_SD_CHK;
        end else begin
          op        = laa_pkg::OP_FIT_W;
          idx_nxt   = '0;
          state_nxt = S_REC_SCAN;
        end
      end
      S_GROW_A: begin
        op        = laa_pkg::OP_GROW_A;
        state_nxt = S_GROW_B;
      end
      S_GROW_B: begin
        op        = laa_pkg::OP_GROW_B;
        idx_nxt   = '0;
        state_nxt = S_REC_SCAN;
      end
      S_REC_SCAN: begin
        if (!stat.slot_valid) begin
          op        = laa_pkg::OP_REC;
          state_nxt = S_OUT;
        end else if (idx_r == LAST_A) begin
          op        = laa_pkg::OP_ST1;
          state_nxt = S_OUT;
        end else idx_nxt = idx_inc;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          op            = laa_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pos_r       <= '0;
      ret_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/lifetime_aliasing_allocator_core.sv]
// Steps per resource: take the beat, rerun the active-table expiry scan after each retirement,
//   release each retired block into the free list (find its position, shift entries, merge
//   with neighbors), try fit candidates in turn and claim one or grow the heap, search for a
//   free active slot, and load the result register (out_tvalid rises the cycle after).
// Throughput: one resource at a time; the active-table expiry scan sets the pace.
// Reset (synchronous, rst_n low): tables and free list empty, heap top zero, no result pending.
`timescale 1ns / 1ps
module lifetime_aliasing_allocator_core #(
  parameter int ACTIVE_DEPTH = laa_pkg::ACTIVE_DEPTH_DEF,
  parameter int FREE_DEPTH   = laa_pkg::FREE_DEPTH_DEF,
  parameter int SIZE_BITS    = laa_pkg::SIZE_BITS_DEF,
  parameter int TIME_BITS    = laa_pkg::TIME_BITS_DEF,
  localparam int IN_FW  = 2 * TIME_BITS + SIZE_BITS + laa_pkg::ALIGN_BITS,
  localparam int IN_W   = (IN_FW + 7) / 8 * 8,
  localparam int OUT_FW = 2 * SIZE_BITS,
  localparam int OUT_W  = (OUT_FW + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // life_begin, life_end, byte_size, align_log2
  input  logic             in_tuser,   // first_of_set
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // placed_offset, heap_total
  output logic [2:0]       out_tuser   // reused_block, status[1:0]
);

  localparam int AW = $clog2(ACTIVE_DEPTH);
  localparam int FW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);
  localparam int B0 = TIME_BITS;
  localparam int B1 = 2 * TIME_BITS;
  localparam int B2 = 2 * TIME_BITS + SIZE_BITS;

  laa_pkg::dp_op_t   op;
  laa_pkg::dp_stat_t stat;
  logic [AW-1:0]     a_addr;
  logic [FW-1:0]     f_addr;
  logic [CW-1:0]     free_cnt;
  logic [SIZE_BITS-1:0] res_offset, res_total;
  logic              res_reused;
  logic [1:0]        res_status;

  laa_ctrl #(
    .ACTIVE_DEPTH(ACTIVE_DEPTH),
    .FREE_DEPTH  (FREE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .free_cnt  (free_cnt),
    .op        (op),
    .a_addr    (a_addr),
    .f_addr    (f_addr)
  );

  laa_dp #(
    .ACTIVE_DEPTH(ACTIVE_DEPTH),
    .FREE_DEPTH  (FREE_DEPTH),
    .SIZE_BITS   (SIZE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .a_addr    (a_addr),
    .f_addr    (f_addr),
    .in_first  (in_tuser),
    .in_begin  (in_tdata[B0-1:0]),
    .in_end    (in_tdata[B1-1:B0]),
    .in_size   (in_tdata[B2-1:B1]),
    .in_align  (in_tdata[IN_FW-1:B2]),
    .stat      (stat),
    .free_cnt  (free_cnt),
    .res_offset(res_offset),
    .res_total (res_total),
    .res_reused(res_reused),
    .res_status(res_status)
  );

  assign out_tdata = OUT_W'({res_total, res_offset});
  assign out_tuser = {res_status, res_reused};

  // busy for at least a full expiry scan after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a beat while the previous one was still in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (op == laa_pkg::OP_OUT) |=> out_tvalid)
    else $error("result register loaded but no beat offered");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt <= CW'(FREE_DEPTH))
    else $error("free list count beyond its depth");

endmodule
